@@ rtl/divisor_count_minus_one_assert.svh @@
// assertion macros for the divisor count block
`ifndef DIVISOR_COUNT_MINUS_ONE_ASSERT_SVH
`define DIVISOR_COUNT_MINUS_ONE_ASSERT_SVH

`ifndef SYNTHESIS
// checked while out of reset
`define DCM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked at every edge, reset included
`define DCM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define DCM_ASSERT(label, prop, msg)
`define DCM_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

@@ rtl/dcm_pkg.sv @@
// shared types and constants for the divisor count block
`default_nettype none

package dcm_pkg;

  localparam int unsigned NUMBER_WIDTH_DEF = 40;

  // running divisor count, wide enough to saturate past the output range
  localparam int unsigned COUNT_W = 15;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam int unsigned BASE_COUNT_W = 14;
  localparam logic [BASE_COUNT_W-1:0] BASE_COUNT_MAX = '1;

  typedef struct packed {
    logic load;
    logic start_div;
    logic take_quot;
    logic close_factor;
    logic double_up;
    logic emit;
  } dcm_cmd_t;

  typedef struct packed {
    logic div_done;
    logic rem_zero;
    logic quot_lt_div;
  } dcm_stat_t;

endpackage

`default_nettype wire

@@ rtl/dcm_number_if.sv @@
// input channel carrying the number to factor
`default_nettype none

interface dcm_number_if #(
  parameter int unsigned NUMBER_WIDTH = dcm_pkg::NUMBER_WIDTH_DEF
);
  logic                    valid;
  logic                    ready;
  logic [NUMBER_WIDTH-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

`default_nettype wire

@@ rtl/dcm_count_if.sv @@
// output channel carrying the base count
`default_nettype none

interface dcm_count_if;
  logic                              valid;
  logic                              ready;
  logic [dcm_pkg::BASE_COUNT_W-1:0]  base_count;

  modport source (output valid, output base_count, input ready);
  modport sink   (input valid, input base_count, output ready);
endinterface

`default_nettype wire

@@ rtl/dcm_divider.sv @@
// restoring divider, one quotient bit per cycle
`default_nettype none

module dcm_divider #(
  parameter int unsigned NUMBER_WIDTH = dcm_pkg::NUMBER_WIDTH_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic [NUMBER_WIDTH-1:0] dividend_i,
  input  wire logic [NUMBER_WIDTH-1:0] divisor_i,
  output logic                         done_o,
  output logic [NUMBER_WIDTH-1:0]      quot_o,
  output logic [NUMBER_WIDTH-1:0]      rem_o
);
  localparam int unsigned CntW = $clog2(NUMBER_WIDTH);

  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [NUMBER_WIDTH-1:0] quot_q, quot_d;
  logic [NUMBER_WIDTH-1:0] rem_q, rem_d;
  logic [NUMBER_WIDTH:0]   shifted;
  logic [NUMBER_WIDTH+1:0] diff;
  logic                    fits;

  // divisor is held steady by the datapath for the whole division
  assign shifted = {rem_q, quot_q[NUMBER_WIDTH-1]};
  assign diff    = {1'b0, shifted} - {2'b00, divisor_i};
  assign fits    = ~diff[NUMBER_WIDTH+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quot_d = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d  = fits ? diff[NUMBER_WIDTH-1:0] : shifted[NUMBER_WIDTH-1:0];
      quot_d = {quot_q[NUMBER_WIDTH-2:0], fits};
      cnt_d  = cnt_q + CntW'(1);
      if (cnt_q == CntW'(NUMBER_WIDTH - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

@@ rtl/dcm_datapath.sv @@
// cofactor, candidate, exponent and count registers around the divider
`default_nettype none

module dcm_datapath #(
  parameter int unsigned NUMBER_WIDTH = dcm_pkg::NUMBER_WIDTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire dcm_pkg::dcm_cmd_t                 cmd_i,
  output dcm_pkg::dcm_stat_t                     stat_o,
  input  wire logic [NUMBER_WIDTH-1:0]           number_i,
  output logic [dcm_pkg::BASE_COUNT_W-1:0]       base_count_o
);
  import dcm_pkg::*;

  localparam int unsigned ExpW  = $clog2(NUMBER_WIDTH + 2);
  localparam int unsigned ProdW = COUNT_W + ExpW;

  logic [NUMBER_WIDTH-1:0] n_q, d_q;
  logic [COUNT_W-1:0]      total_q;
  logic [ExpW-1:0]         exp_q;
  logic [BASE_COUNT_W-1:0] base_count_q;

  logic                    div_done;
  logic [NUMBER_WIDTH-1:0] quot, rem;
  logic [ExpW-1:0]         mul_b;
  logic [ProdW-1:0]        product;
  logic [COUNT_W-1:0]      prod_sat;
  logic [COUNT_W-1:0]      total_m1;
  logic [NUMBER_WIDTH-1:0] d_next;

  dcm_divider #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.start_div),
    .dividend_i(n_q),
    .divisor_i (d_q),
    .done_o    (div_done),
    .quot_o    (quot),
    .rem_o     (rem)
  );

  assign stat_o.div_done    = div_done;
  assign stat_o.rem_zero    = (rem == '0);
  assign stat_o.quot_lt_div = (quot < d_q);

  // closing a prime multiplies by exponent+1, a leftover prime cofactor by two
  always_comb begin
    if (cmd_i.double_up) begin
      mul_b = (n_q > NUMBER_WIDTH'(1)) ? ExpW'(2) : ExpW'(1);
    end else begin
      mul_b = exp_q;
    end
  end

  assign product  = {{ExpW{1'b0}}, total_q} * {{COUNT_W{1'b0}}, mul_b};
  assign prod_sat = (product > ProdW'(COUNT_MAX)) ? COUNT_MAX : product[COUNT_W-1:0];

  // 2, then odd candidates
  assign d_next = (d_q == NUMBER_WIDTH'(2)) ? NUMBER_WIDTH'(3) : d_q + NUMBER_WIDTH'(2);

  assign total_m1 = total_q - COUNT_W'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q     <= number_i;
      d_q     <= NUMBER_WIDTH'(2);
      total_q <= COUNT_W'(1);
      exp_q   <= ExpW'(1);
    end
    if (cmd_i.take_quot) begin
      n_q   <= quot;
      exp_q <= exp_q + ExpW'(1);
    end
    if (cmd_i.close_factor) begin
      total_q <= prod_sat;
      exp_q   <= ExpW'(1);
      d_q     <= d_next;
    end
    if (cmd_i.double_up) begin
      total_q <= prod_sat;
    end
    if (cmd_i.emit) begin
      base_count_q <= (total_m1 > COUNT_W'(BASE_COUNT_MAX)) ? BASE_COUNT_MAX
                                                            : total_m1[BASE_COUNT_W-1:0];
    end
  end

  assign base_count_o = base_count_q;

endmodule

`default_nettype wire

@@ rtl/dcm_ctrl.sv @@
// controller sequencing trial divisions and the output word
`default_nettype none

`include "divisor_count_minus_one_assert.svh"

module dcm_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire dcm_pkg::dcm_stat_t stat_i,
  output dcm_pkg::dcm_cmd_t       cmd_o
);
  import dcm_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_START  = 3'd1;
  localparam logic [2:0] S_WAIT   = 3'd2;
  localparam logic [2:0] S_FINAL  = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  logic [2:0] state_q, state_d;
  logic       inner_q, inner_d;
  logic       out_valid_q, out_valid_d;
  logic       in_accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    inner_d = inner_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          inner_d    = 1'b0;
          state_d    = S_START;
        end
      end
      S_START: begin
        cmd_o.start_div = 1'b1;
        state_d         = S_WAIT;
      end
      S_WAIT: begin
        if (stat_i.div_done) begin
          // the square-root bound is only tested before a new candidate
          if (!inner_q && stat_i.quot_lt_div) begin
            state_d = S_FINAL;
          end else if (stat_i.rem_zero) begin
            cmd_o.take_quot = 1'b1;
            inner_d         = 1'b1;
            state_d         = S_START;
          end else begin
            cmd_o.close_factor = 1'b1;
            inner_d            = 1'b0;
            state_d            = S_START;
          end
        end
      end
      S_FINAL: begin
        cmd_o.double_up = 1'b1;
        state_d         = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      inner_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      inner_q     <= inner_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `DCM_ASSERT(a_accept_starts, in_accept |=> state_q == S_START, "accepted word did not start")
  `DCM_ASSERT(a_cmd_onehot, $onehot0(cmd_o), "overlapping commands")
  `DCM_ASSERT(a_done_in_wait, stat_i.div_done |-> state_q == S_WAIT, "divider done outside wait")
  `DCM_ASSERT(a_emit_free, cmd_o.emit |-> (!out_valid_q || out_ready_i), "pending word overwritten")
  `DCM_ASSERT_ALWAYS(a_reset_clears, !rst_ni |=> !out_valid_q, "output valid after reset")

endmodule

`default_nettype wire

@@ rtl/divisor_count_minus_one.sv @@
// divisor_count_minus_one: number of divisors of a positive integer, minus one
//
// in_i takes one word holding number; out_o returns one word holding
// base_count, the divisor count of number minus one (saturated at 16383).
// Both channels move a word when valid and ready are high at a clock edge.
// The block factors the number by trial division with 2 and then odd
// candidates, using one restoring divider that yields one quotient bit a
// cycle. in_i.ready returns in the same cycle that the output register
// is loaded with the finished word.
// One item is worked on at a time; in_i.ready is high only between items.
// The finished word sits in an output register, so a stalled receiver does
// not hold back the next input; a further result waits until it is taken.
// Reset (rst_ni low, asynchronous) drops any item in flight, clears the
// output valid and leaves the block ready for a new word.
`default_nettype none

module divisor_count_minus_one #(
  parameter int unsigned NUMBER_WIDTH = dcm_pkg::NUMBER_WIDTH_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  dcm_number_if.sink  in_i,
  dcm_count_if.source out_o
);
  import dcm_pkg::*;

  dcm_cmd_t  cmd;
  dcm_stat_t stat;

  dcm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dcm_datapath #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .number_i    (in_i.number),
    .base_count_o(out_o.base_count)
  );

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// self-checking testbench for the divisor count block: corner numbers, output stall, random
`timescale 1ns / 100ps

module testbench;
  import dcm_pkg::*;

  localparam int unsigned NUMBER_WIDTH = NUMBER_WIDTH_DEF;
  localparam longint unsigned NUMBER_MASK = (64'd1 << NUMBER_WIDTH) - 1;
  localparam int unsigned LONG_HOLD_CYCLES = 3000;
  // quiet time after the last word, long enough for a stray word to appear
  localparam int unsigned DRAIN_CYCLES = 16384;

  typedef struct {
    logic [NUMBER_WIDTH-1:0] number;
    logic [BASE_COUNT_W-1:0] base_count;
  } count_expect_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  dcm_number_if #(.NUMBER_WIDTH(NUMBER_WIDTH)) number_ch ();
  dcm_count_if count_ch ();

  divisor_count_minus_one #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (number_ch),
    .out_o (count_ch)
  );

  count_expect_t expected_counts[$];
  int unsigned error_count = 0;
  int unsigned numbers_sent = 0;
  int unsigned results_checked = 0;
  int unsigned hold_requests = 0;
  bit no_idle = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // divisor count minus one by trial division with 2 and then odd candidates
  function automatic logic [BASE_COUNT_W-1:0] count_zero_ending_bases(
    input logic [NUMBER_WIDTH-1:0] value
  );
    longint unsigned rest;
    longint unsigned cand;
    int unsigned divisors;
    int unsigned power;
    rest = value;
    if (rest == 0) return '0;
    divisors = 1;
    cand = 2;
    while (cand * cand <= rest) begin
      power = 0;
      while (rest % cand == 0) begin
        rest = rest / cand;
        power++;
      end
      divisors = divisors * (power + 1);
      cand = (cand == 2) ? 3 : cand + 2;
    end
    if (rest > 1) divisors = divisors * 2;
    divisors = divisors - 1;
    if (divisors > BASE_COUNT_MAX) return BASE_COUNT_MAX;
    return divisors[BASE_COUNT_W-1:0];
  endfunction

  task automatic send_number(input logic [NUMBER_WIDTH-1:0] value);
    int unsigned gap;
    gap = (!no_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    if (gap != 0) begin
      @(negedge clk_i);
      number_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    number_ch.valid  <= 1'b1;
    number_ch.number <= value;
    do @(posedge clk_i); while (number_ch.ready !== 1'b1);
    expected_counts.push_back(count_expect_t'{number: value,
                                              base_count: count_zero_ending_bases(value)});
    numbers_sent++;
  endtask

  task automatic test_corner_numbers();
    longint unsigned corners[$];
    corners = '{
      64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd97, 64'd720720,
      NUMBER_MASK,                 // all ones
      64'h80_0000_0000,            // top bit alone
      64'h55_5555_5555, 64'hAA_AAAA_AAAA,
      64'd963761198400,            // most divisors in 40 bits
      64'd200560490130,            // first eleven primes
      64'd847288609443,            // 3 to the 25th
      64'd1042441,                 // square of a prime, search ends at equality
      64'd1040399,                 // two neighboring primes
      64'd16777213 << 16           // large prime left after the twos
    };
    foreach (corners[i]) send_number(corners[i][NUMBER_WIDTH-1:0]);
  endtask

  // receiver holds off while the sender keeps offering, so the block backs up
  task automatic test_stalled_receiver();
    hold_requests++;
    no_idle = 1'b1;
    send_number(60);
    send_number(97);
    send_number(210);
    send_number(255);
    no_idle = 1'b0;
  endtask

  task automatic test_random_numbers(input int unsigned count);
    longint unsigned value;
    longint unsigned factor;
    repeat (count) begin
      if ($urandom_range(0, 2) == 0) begin
        value = $urandom_range(1, 65535);
      end else begin
        value = 1;
        // factors below 512 only, so the trial search stays short
        repeat ($urandom_range(1, 16)) begin
          factor = $urandom_range(2, 511);
          if (value * factor <= NUMBER_MASK) value = value * factor;
        end
      end
      send_number(value[NUMBER_WIDTH-1:0]);
    end
  endtask

  initial begin : drive_count_ready
    int unsigned stall_left;
    int unsigned holds_served;
    stall_left = 0;
    holds_served = 0;
    count_ch.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        stall_left = LONG_HOLD_CYCLES;
      end
      if (stall_left != 0) begin
        stall_left--;
        count_ch.ready <= 1'b0;
      end else begin
        count_ch.ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 7);
      end
    end
  end

  always @(posedge clk_i) begin : check_counts
    count_expect_t want;
    if (rst_ni && count_ch.valid === 1'b1 && count_ch.ready === 1'b1) begin
      if (expected_counts.size() == 0) begin
        $error("unexpected word: base_count %0d", count_ch.base_count);
        error_count++;
      end else begin
        want = expected_counts.pop_front();
        if (count_ch.base_count !== want.base_count) begin
          $error("base_count for number %0d: expected %0d, actual %0d",
                 want.number, want.base_count, count_ch.base_count);
          error_count++;
        end
        results_checked++;
      end
    end
  end

  initial begin
    number_ch.valid  <= 1'b0;
    number_ch.number <= '0;
    rst_ni <= 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_corner_numbers();
    test_stalled_receiver();
    test_random_numbers(60);
    no_idle = 1'b1;
    test_random_numbers(20);

    @(negedge clk_i);
    number_ch.valid <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk_i);
    // a stray word would show up here
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("checked %0d base counts for %0d numbers", results_checked, numbers_sent);
    $display("covered corner values, a long output stall, random smooth and small numbers");
    if (error_count == 0) begin
      $display("PASS divisor_count_minus_one");
    end else begin
      $display("FAIL divisor_count_minus_one");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("FAIL divisor_count_minus_one");
    $finish;
  end

endmodule
